/* src/assert_macros.svh */
// Assertion macros shared by the tokenizer RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER_AT_CLK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

/* src/sqlkt_pkg.sv */
// Types, token codes, keyword table and byte classifiers for the SQL keyword tokenizer.
// No dependencies.
package sqlkt_pkg;

  localparam int KIND_W   = 6;
  localparam int START_W  = 16;
  localparam int LENGTH_W = 16;

  localparam logic [LENGTH_W-1:0] LEN_MAX = '1;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_IDENT         = 6'd0;
  localparam logic [KIND_W-1:0] KIND_NUMBER        = 6'd1;
  localparam logic [KIND_W-1:0] KIND_END           = 6'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR         = 6'd3;
  localparam logic [KIND_W-1:0] KIND_SEMI          = 6'd4;
  localparam logic [KIND_W-1:0] KIND_COMMA         = 6'd5;
  localparam logic [KIND_W-1:0] KIND_STAR          = 6'd6;
  localparam logic [KIND_W-1:0] KIND_EQUAL         = 6'd7;
  localparam logic [KIND_W-1:0] KIND_LESS          = 6'd8;
  localparam logic [KIND_W-1:0] KIND_GREATER       = 6'd9;
  localparam logic [KIND_W-1:0] KIND_LPAREN        = 6'd10;
  localparam logic [KIND_W-1:0] KIND_RPAREN        = 6'd11;
  localparam logic [KIND_W-1:0] KIND_QUOTE         = 6'd12;
  localparam logic [KIND_W-1:0] KIND_FIRST_KEYWORD = 6'd13;

  localparam int KEYWORD_COUNT = 20;
  localparam int KW_TEXT_W     = 48;

  // Keyword spellings, lowercase, first character in the low byte, zero padded.
  localparam logic [KW_TEXT_W-1:0] KW_TEXT [KEYWORD_COUNT] = '{
    48'h7463_656c_6573,  // select
    48'h0000_0074_6573,  // set
    48'h0000_6d6f_7266,  // from
    48'h0065_7265_6877,  // where
    48'h0000_0064_6e61,  // and
    48'h0072_6574_6c61,  // alter
    48'h0000_0064_6461,  // add
    48'h0000_0063_7361,  // asc
    48'h0070_756f_7267,  // group
    48'h676e_6976_6168,  // having
    48'h0072_6564_726f,  // order
    48'h0000_0000_7962,  // by
    48'h0000_6373_6564,  // desc
    48'h6574_656c_6564,  // delete
    48'h6574_6165_7263,  // create
    48'h0065_6c62_6174,  // table
    48'h7472_6573_6e69,  // insert
    48'h0000_6f74_6e69,  // into
    48'h7365_756c_6176,  // values
    48'h6574_6164_7075   // update
  };

  localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{
    3'd6, 3'd3, 3'd4, 3'd5, 3'd3, 3'd5, 3'd3, 3'd3, 3'd5, 3'd6,
    3'd5, 3'd2, 3'd4, 3'd6, 3'd6, 3'd5, 3'd6, 3'd4, 3'd6, 3'd6
  };

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int COUNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
    logic                last;
  } token_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
           (b == 8'h5f) || (b >= 8'hc0);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || b == 8'h0d || b == 8'h0a || b == 8'h09;
  endfunction

  // Only ASCII A-Z fold.
  function automatic logic [7:0] fold(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] b);
    logic [KIND_W-1:0] k;
    unique case (b)
      8'h3b:   k = KIND_SEMI;
      8'h2c:   k = KIND_COMMA;
      8'h2a:   k = KIND_STAR;
      8'h3d:   k = KIND_EQUAL;
      8'h3c:   k = KIND_LESS;
      8'h3e:   k = KIND_GREATER;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h27:   k = KIND_QUOTE;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

/* src/sql_keyword_tokenizer.sv */
// A token is written into the result queue when the byte that closes it is transferred.
// Throughput: one byte per cycle while in_ready is high; a byte that closes a token and makes another
// writes two queue entries, absorbed by a 4-entry result queue; input stalls when fewer than 2 are free.
// Reset (rst, synchronous): scanner idle, position and start zero, result queue empty.
// Depends on sqlkt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sql_keyword_tokenizer
  import sqlkt_pkg::*;
#(
  parameter int POS_BITS          = 16,
  parameter int KEYWORD_MAX_CHARS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          char_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   token_kind,
  output logic [START_W-1:0]  token_offset,
  output logic [LENGTH_W-1:0] token_length,
  output logic                last_of_run
);

  localparam int KW_BITS = 8 * KEYWORD_MAX_CHARS;

  // Scanner state
  mode_t                scan_mode, scan_mode_next;
  logic [POS_BITS-1:0]  token_start_pos, token_start_pos_next;
  logic [POS_BITS-1:0]  byte_position, byte_position_next;
  logic [LENGTH_W-1:0]  pending_length, pending_length_next;
  logic [KW_BITS-1:0]   keyword_chars, keyword_chars_next;

  // Result queue
  token_t               fifo_mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr, wr_ptr_next;
  logic [PTR_BITS-1:0]  rd_ptr, rd_ptr_next;
  logic [COUNT_BITS-1:0] fifo_count, fifo_count_next;

  logic                 in_fire, out_fire;
  logic                 emit_a, emit_b;
  token_t               tok_a, tok_b, slot0;
  logic [KIND_W-1:0]    ident_kind;
  logic                 byte_letter, byte_digit;
  token_t               head;

  assign in_ready  = fifo_count <= COUNT_BITS'(FIFO_DEPTH - 2);
  assign out_valid = fifo_count != '0;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign byte_letter = is_letter(char_byte);
  assign byte_digit  = is_digit(char_byte);

  // Parallel keyword match on the pending identifier
  always_comb begin
    ident_kind = KIND_IDENT;
    for (int i = 0; i < KEYWORD_COUNT; i++) begin
      if (pending_length == LENGTH_W'(KW_LEN[i]) &&
          keyword_chars == KW_BITS'(KW_TEXT[i])) begin
        ident_kind = KIND_FIRST_KEYWORD + KIND_W'(i);
      end
    end
  end

  // Next scanner state and tokens for the byte being transferred
  always_comb begin
    scan_mode_next       = scan_mode;
    token_start_pos_next = token_start_pos;
    byte_position_next   = byte_position;
    pending_length_next  = pending_length;
    keyword_chars_next   = keyword_chars;
    emit_a               = 1'b0;
    emit_b               = 1'b0;
    tok_a.kind           = (scan_mode == MODE_IDENT) ? ident_kind : KIND_NUMBER;
    tok_a.start          = START_W'(token_start_pos);
    tok_a.length         = pending_length;
    tok_b.kind           = punct_kind(char_byte);
    tok_b.start          = START_W'(byte_position);
    tok_b.length         = LENGTH_W'(1);
    tok_b.last           = 1'b1;

    if (in_fire) begin
      if ((scan_mode == MODE_IDENT && (byte_letter || byte_digit)) ||
          (scan_mode == MODE_NUMBER && byte_digit)) begin
        if (scan_mode == MODE_IDENT) begin
          for (int j = 0; j < KEYWORD_MAX_CHARS; j++) begin
            if (pending_length == LENGTH_W'(j)) begin
              keyword_chars_next[8*j +: 8] = fold(char_byte);
            end
          end
        end
        if (pending_length != LEN_MAX) begin
          pending_length_next = pending_length + LENGTH_W'(1);
        end
        byte_position_next = byte_position + POS_BITS'(1);
      end else begin
        // pending token closes; the unused mode code acts as idle
        emit_a              = (scan_mode == MODE_IDENT) || (scan_mode == MODE_NUMBER);
        scan_mode_next      = MODE_IDLE;
        pending_length_next = '0;
        keyword_chars_next  = '0;
        if (char_byte == 8'h00) begin
          emit_b               = 1'b1;
          tok_b.kind           = KIND_END;
          tok_b.length         = '0;
          byte_position_next   = '0;
          token_start_pos_next = '0;
        end else begin
          if (is_space(char_byte)) begin
            // skipped
          end else if (byte_letter) begin
            scan_mode_next       = MODE_IDENT;
            token_start_pos_next = byte_position;
            pending_length_next  = LENGTH_W'(1);
            keyword_chars_next   = KW_BITS'(fold(char_byte));
          end else if (byte_digit) begin
            scan_mode_next       = MODE_NUMBER;
            token_start_pos_next = byte_position;
            pending_length_next  = LENGTH_W'(1);
          end else begin
            emit_b               = 1'b1;
            token_start_pos_next = byte_position;
          end
          byte_position_next = byte_position + POS_BITS'(1);
        end
      end
    end
    tok_a.last = !emit_b;
  end

  // Queue bookkeeping
  always_comb begin
    slot0           = emit_a ? tok_a : tok_b;
    wr_ptr_next     = wr_ptr + PTR_BITS'(emit_a) + PTR_BITS'(emit_b);
    rd_ptr_next     = out_fire ? rd_ptr + PTR_BITS'(1) : rd_ptr;
    fifo_count_next = fifo_count + COUNT_BITS'(emit_a) + COUNT_BITS'(emit_b)
                      - COUNT_BITS'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= MODE_IDLE;
      token_start_pos <= '0;
      byte_position   <= '0;
      pending_length  <= '0;
      keyword_chars   <= '0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      fifo_count      <= '0;
    end else begin
      scan_mode       <= scan_mode_next;
      token_start_pos <= token_start_pos_next;
      byte_position   <= byte_position_next;
      pending_length  <= pending_length_next;
      keyword_chars   <= keyword_chars_next;
      wr_ptr          <= wr_ptr_next;
      rd_ptr          <= rd_ptr_next;
      fifo_count      <= fifo_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_a || emit_b) begin
      fifo_mem[wr_ptr] <= slot0;
    end
    if (emit_a && emit_b) begin
      fifo_mem[wr_ptr + PTR_BITS'(1)] <= tok_b;
    end
  end

  assign head         = fifo_mem[rd_ptr];
  assign token_kind   = head.kind;
  assign token_offset = head.start;
  assign token_length = head.length;
  assign last_of_run  = head.last;

  `ASSERT_AT_CLK(a_fifo_bound, fifo_count <= COUNT_BITS'(FIFO_DEPTH), "result queue overflow")
  `ASSERT_AT_CLK(a_mode_len, (scan_mode == MODE_IDLE) == (pending_length == '0),
                 "mode and length disagree")
  `ASSERT_AT_CLK(a_nul_reset, in_fire && char_byte == 8'h00 |=> byte_position == '0,
                 "position not cleared after end of string")
  `ASSERT_NEVER_AT_CLK(a_no_mode3,
                       scan_mode != MODE_IDLE && scan_mode != MODE_IDENT &&
                       scan_mode != MODE_NUMBER && fifo_count == '0 && pending_length != '0,
                       "scanner in unused mode with pending token")

endmodule
